// ===== src/url_shp_pkg.sv =====
`default_nettype none

package url_shp_pkg;

    localparam int TABLE_SIZE = 22;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_USE_DEFAULTS    = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_PROT    = 2'd1;
    localparam logic [1:0] CFG_PORT_OVR_VALID  = 2'd2;
    localparam logic [1:0] CFG_PORT_OVR        = 2'd3;

    localparam logic [4:0]  PROTO_ID_NONE = 5'd0;
    localparam logic [4:0]  PROTO_ID_HTTP = 5'd1;
    localparam logic [15:0] PORT_HTTP     = 16'd80;

    // Scheme names, right-justified: the last character sits in the low byte.
    localparam logic [55:0] SCH_NAME [TABLE_SIZE] = '{
        56'("http"), 56'("https"), 56'("smtp"), 56'("smtps"),
        56'("pop3"), 56'("pop"), 56'("pop3s"), 56'("pops"),
        56'("imap"), 56'("imap4"), 56'("imaps"), 56'("imap4s"),
        56'("ldap"), 56'("ldaps"), 56'("syncml"), 56'("syncmls"),
        56'("ftp"), 56'("tftp"), 56'("sftp"), 56'("gopher"),
        56'("rsync"), 56'("finger")
    };

    localparam logic [2:0] SCH_LEN [TABLE_SIZE] = '{
        3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5,
        3'd6, 3'd4, 3'd5, 3'd6, 3'd7, 3'd3, 3'd4, 3'd4, 3'd6, 3'd5, 3'd6
    };

    localparam logic [4:0] SCH_PROT [TABLE_SIZE] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd5, 5'd6, 5'd6, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17
    };

    localparam logic SCH_SSL [TABLE_SIZE] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
    };

    localparam logic [15:0] SCH_PORT [TABLE_SIZE] = '{
        16'd80, 16'd443, 16'd25, 16'd465, 16'd110, 16'd110, 16'd995, 16'd995,
        16'd143, 16'd143, 16'd993, 16'd993, 16'd389, 16'd636, 16'd8443,
        16'd8443, 16'd21, 16'd69, 16'd115, 16'd70, 16'd873, 16'd79
    };

    // Character k of entry e; only meaningful while k is below the entry length.
    function automatic logic [7:0] sch_char(input logic [4:0] e, input logic [2:0] k);
        logic [2:0]  r;
        logic [55:0] w;
        r = SCH_LEN[e] - k - 3'd1;
        w = SCH_NAME[e] >> {r, 3'b000};
        return w[7:0];
    endfunction

    // Fixed-width part of one finished URL as handed from scanner to finisher.
    typedef struct packed {
        logic        err;
        logic [1:0]  code;
        logic [4:0]  matched;
        logic [15:0] port;
        logic        path_seen;
    } url_fix_t;

endpackage

`default_nettype wire

// ===== src/url_shp_fifo.sv =====
`default_nettype none

module url_shp_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    output logic                  rd_valid,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr_en) begin
            wptr_next = ~wptr_reg;
        end
        if (rd_en) begin
            rptr_next = ~rptr_reg;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 2'd1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/url_shp_front.sv =====
`default_nettype none

module url_shp_front #(
    parameter int PW = 10,
    parameter int NE = 22,
    parameter int MAX_BYTES = 1024,
    parameter int REC_W = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_ch,
    output logic                  in_ready,
    output logic                  rec_push,
    output logic [REC_W-1:0]      rec_data,
    input  wire logic             rec_full
);
    import url_shp_pkg::*;

    localparam logic [2:0] PH_SCHEME  = 3'd0;
    localparam logic [2:0] PH_COLON1  = 3'd1;
    localparam logic [2:0] PH_COLON2  = 3'd2;
    localparam logic [2:0] PH_SLASHES = 3'd3;
    localparam logic [2:0] PH_HOST    = 3'd4;
    localparam logic [2:0] PH_PORT    = 3'd5;
    localparam logic [2:0] PH_PATH    = 3'd6;
    localparam logic [2:0] PH_ERROR   = 3'd7;

    localparam logic [PW-1:0] POS_LAST = PW'(MAX_BYTES - 1);

    logic [2:0]    phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [NE-1:0] match_reg, match_next;
    logic [3:0]    slen_reg, slen_next;
    logic [PW-1:0] hbeg_reg, hbeg_next;
    logic [PW-1:0] hend_reg, hend_next;
    logic [15:0]   port_reg, port_next;
    logic [PW-1:0] pbeg_reg, pbeg_next;
    logic          pseen_reg, pseen_next;
    logic [4:0]    ment_reg, ment_next;

    logic          accept;
    logic          is_upper, is_letter, is_digit, is_path, is_colon, is_slash;
    logic [7:0]    low_ch;
    logic [19:0]   port_mul;
    logic [15:0]   port_sat;
    logic          hit_found;
    logic [4:0]    hit_entry;

    url_fix_t      fix;
    logic [PW-1:0] fin_hbeg, fin_hend, fin_pbeg;
    logic          fin_pseen;

    assign in_ready = !rec_full;
    assign accept   = in_valid && in_ready;
    assign rec_push = accept && (in_ch == 8'd0);

    assign is_upper  = (in_ch >= "A") && (in_ch <= "Z");
    assign is_letter = is_upper || ((in_ch >= "a") && (in_ch <= "z"));
    assign is_digit  = (in_ch >= "0") && (in_ch <= "9");
    assign is_path   = (in_ch == "/") || (in_ch == "?");
    assign is_colon  = (in_ch == ":");
    assign is_slash  = (in_ch == "/");
    assign low_ch    = is_upper ? (in_ch + 8'd32) : in_ch;

    assign port_mul = {4'd0, port_reg} * 20'd10 + {16'd0, in_ch[3:0]};
    assign port_sat = (port_mul > 20'd65535) ? 16'hFFFF : port_mul[15:0];

    // First table entry still matching whose length equals the scheme run.
    always_comb begin
        hit_found = 1'b0;
        hit_entry = 5'd0;
        for (int e = NE - 1; e >= 0; e--) begin
            if (match_reg[e] && ({1'b0, SCH_LEN[e]} == slen_reg)) begin
                hit_found = 1'b1;
                hit_entry = 5'(e + 1);
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        slen_next  = slen_reg;
        hbeg_next  = hbeg_reg;
        hend_next  = hend_reg;
        port_next  = port_reg;
        pbeg_next  = pbeg_reg;
        pseen_next = pseen_reg;
        ment_next  = ment_reg;

        if (accept) begin
            if (in_ch == 8'd0) begin
                phase_next = PH_SCHEME;
                pos_next   = '0;
                match_next = '1;
                slen_next  = 4'd0;
                hbeg_next  = '0;
                hend_next  = '0;
                port_next  = 16'd0;
                pbeg_next  = '0;
                pseen_next = 1'b0;
                ment_next  = 5'd0;
            end else if (phase_reg != PH_ERROR) begin
                if (pos_reg >= POS_LAST) begin
                    phase_next = PH_ERROR;
                    ment_next  = {3'd0, ST_TOO_LONG};
                end else begin
                    pos_next = pos_reg + 1'b1;
                    case (phase_reg)
                        PH_SCHEME: begin
                            if (is_letter || (is_digit && (slen_reg != 4'd0))) begin
                                for (int e = 0; e < NE; e++) begin
                                    if (({1'b0, SCH_LEN[e]} <= slen_reg) ||
                                        (sch_char(5'(e), slen_reg[2:0]) != low_ch)) begin
                                        match_next[e] = 1'b0;
                                    end
                                end
                                if (slen_reg != 4'd15) begin
                                    slen_next = slen_reg + 4'd1;
                                end
                            end else if (is_colon) begin
                                hend_next  = pos_reg;
                                phase_next = PH_COLON1;
                            end else if (is_path) begin
                                hend_next  = pos_reg;
                                pbeg_next  = pos_reg;
                                pseen_next = 1'b1;
                                phase_next = PH_PATH;
                            end else begin
                                phase_next = PH_HOST;
                            end
                        end
                        PH_COLON1: begin
                            if (is_slash) begin
                                phase_next = PH_COLON2;
                            end else if (is_digit) begin
                                port_next  = port_sat;
                                phase_next = PH_PORT;
                            end else begin
                                pbeg_next  = pos_reg;
                                pseen_next = 1'b1;
                                phase_next = PH_PATH;
                            end
                        end
                        PH_COLON2: begin
                            if (is_slash) begin
                                if (hit_found) begin
                                    ment_next  = hit_entry;
                                    phase_next = PH_SLASHES;
                                end else begin
                                    ment_next  = {3'd0, ST_UNKNOWN};
                                    phase_next = PH_ERROR;
                                end
                            end else begin
                                pbeg_next  = pos_reg - 1'b1;
                                pseen_next = 1'b1;
                                phase_next = PH_PATH;
                            end
                        end
                        PH_SLASHES: begin
                            if (!is_slash) begin
                                hbeg_next = pos_reg;
                                if (is_path) begin
                                    hend_next  = pos_reg;
                                    pbeg_next  = pos_reg;
                                    pseen_next = 1'b1;
                                    phase_next = PH_PATH;
                                end else if (is_colon) begin
                                    hend_next  = pos_reg;
                                    phase_next = PH_PORT;
                                end else begin
                                    phase_next = PH_HOST;
                                end
                            end
                        end
                        PH_HOST: begin
                            if (is_path) begin
                                hend_next  = pos_reg;
                                pbeg_next  = pos_reg;
                                pseen_next = 1'b1;
                                phase_next = PH_PATH;
                            end else if (is_colon) begin
                                hend_next  = pos_reg;
                                phase_next = PH_PORT;
                            end
                        end
                        PH_PORT: begin
                            if (is_digit) begin
                                port_next = port_sat;
                            end else begin
                                pbeg_next  = pos_reg;
                                pseen_next = 1'b1;
                                phase_next = PH_PATH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // Close out the phase the URL ended in.
    always_comb begin
        fin_hbeg  = hbeg_reg;
        fin_hend  = hend_reg;
        fin_pbeg  = pbeg_reg;
        fin_pseen = pseen_reg;
        case (phase_reg)
            PH_SCHEME: begin
                fin_hend = pos_reg;
            end
            PH_COLON2: begin
                fin_pbeg  = pos_reg - 1'b1;
                fin_pseen = 1'b1;
            end
            PH_SLASHES: begin
                fin_hbeg = pos_reg;
                fin_hend = pos_reg;
            end
            PH_HOST: begin
                fin_hend = pos_reg;
            end
            default: begin
            end
        endcase
        fix.err       = (phase_reg == PH_ERROR);
        fix.code      = ment_reg[1:0];
        fix.matched   = ment_reg;
        fix.port      = port_reg;
        fix.path_seen = fin_pseen;
    end

    assign rec_data = {fix, fin_hbeg, fin_hend, fin_pbeg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SCHEME;
            pos_reg   <= '0;
            match_reg <= '1;
            slen_reg  <= 4'd0;
            hbeg_reg  <= '0;
            hend_reg  <= '0;
            port_reg  <= 16'd0;
            pbeg_reg  <= '0;
            pseen_reg <= 1'b0;
            ment_reg  <= 5'd0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            slen_reg  <= slen_next;
            hbeg_reg  <= hbeg_next;
            hend_reg  <= hend_next;
            port_reg  <= port_next;
            pbeg_reg  <= pbeg_next;
            pseen_reg <= pseen_next;
            ment_reg  <= ment_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/url_shp_back.sv =====
`default_nettype none

module url_shp_back #(
    parameter int PW = 10,
    parameter int NE = 22,
    parameter int REC_W = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_data,
    output logic                  cfg_ready,
    input  wire logic             rec_valid,
    input  wire logic [REC_W-1:0] rec_data,
    output logic                  rec_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            out_status,
    output logic [4:0]            out_protocol,
    output logic                  out_ssl,
    output logic [15:0]           out_port_number,
    output logic [9:0]            out_host_start,
    output logic [9:0]            out_host_length,
    output logic                  out_path_present,
    output logic [9:0]            out_path_start
);
    import url_shp_pkg::*;

    logic        use_def_reg;
    logic [4:0]  def_prot_reg;
    logic        ovr_valid_reg;
    logic [15:0] ovr_port_reg;

    logic        valid_reg, valid_next;
    logic [1:0]  status_reg, status_next;
    logic [4:0]  prot_reg, prot_next;
    logic        ssl_reg, ssl_next;
    logic [15:0] port_reg, port_next;
    logic [9:0]  hstart_reg, hstart_next;
    logic [9:0]  hlen_reg, hlen_next;
    logic        ppres_reg, ppres_next;
    logic [9:0]  pstart_reg, pstart_next;

    url_fix_t      fix;
    logic [PW-1:0] hbeg, hend, pbeg;
    logic [4:0]    midx;
    logic [4:0]    d_prot;
    logic          d_ssl;
    logic [15:0]   d_port;
    logic [4:0]    prot;
    logic          ssl;
    logic [15:0]   dport;
    logic [15:0]   port;
    logic [1:0]    status;

    assign cfg_ready = 1'b1;
    assign {fix, hbeg, hend, pbeg} = rec_data;
    assign rec_pop = rec_valid && (!valid_reg || out_ready);
    assign midx = fix.matched - 5'd1;

    // Configured default protocol resolved against the table; unknown ids fall back to http.
    always_comb begin
        d_prot = PROTO_ID_HTTP;
        d_ssl  = 1'b0;
        d_port = PORT_HTTP;
        for (int e = NE - 1; e >= 0; e--) begin
            if (SCH_PROT[e] == def_prot_reg) begin
                d_prot = SCH_PROT[e];
                d_ssl  = SCH_SSL[e];
                d_port = SCH_PORT[e];
            end
        end
    end

    always_comb begin
        if (fix.err) begin
            status = fix.code;
        end else if (hend == hbeg) begin
            status = ST_INVALID;
        end else begin
            status = ST_OK;
        end

        prot  = PROTO_ID_NONE;
        ssl   = 1'b0;
        dport = PORT_HTTP;
        if (fix.matched != 5'd0) begin
            prot  = SCH_PROT[midx];
            ssl   = SCH_SSL[midx];
            dport = SCH_PORT[midx];
        end
        port = fix.port;
        if (use_def_reg) begin
            if (prot == PROTO_ID_NONE) begin
                prot  = d_prot;
                ssl   = d_ssl;
                dport = d_port;
            end
            if (port == 16'd0) begin
                port = ovr_valid_reg ? ovr_port_reg : dport;
            end
        end
    end

    always_comb begin
        valid_next  = valid_reg;
        status_next = status_reg;
        prot_next   = prot_reg;
        ssl_next    = ssl_reg;
        port_next   = port_reg;
        hstart_next = hstart_reg;
        hlen_next   = hlen_reg;
        ppres_next  = ppres_reg;
        pstart_next = pstart_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (rec_pop) begin
            valid_next  = 1'b1;
            status_next = status;
            if (status == ST_OK) begin
                prot_next   = prot;
                ssl_next    = ssl;
                port_next   = port;
                hstart_next = 10'(hbeg);
                hlen_next   = 10'(hend - hbeg);
                ppres_next  = fix.path_seen;
                pstart_next = fix.path_seen ? 10'(pbeg) : 10'd0;
            end else begin
                prot_next   = PROTO_ID_NONE;
                ssl_next    = 1'b0;
                port_next   = 16'd0;
                hstart_next = 10'd0;
                hlen_next   = 10'd0;
                ppres_next  = 1'b0;
                pstart_next = 10'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_def_reg   <= 1'b0;
            def_prot_reg  <= PROTO_ID_HTTP;
            ovr_valid_reg <= 1'b0;
            ovr_port_reg  <= 16'd0;
            valid_reg     <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_USE_DEFAULTS:   use_def_reg   <= cfg_data[0];
                    CFG_DEFAULT_PROT:   def_prot_reg  <= cfg_data[4:0];
                    CFG_PORT_OVR_VALID: ovr_valid_reg <= cfg_data[0];
                    CFG_PORT_OVR:       ovr_port_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        prot_reg   <= prot_next;
        ssl_reg    <= ssl_next;
        port_reg   <= port_next;
        hstart_reg <= hstart_next;
        hlen_reg   <= hlen_next;
        ppres_reg  <= ppres_next;
        pstart_reg <= pstart_next;
    end

    assign out_valid        = valid_reg;
    assign out_status       = status_reg;
    assign out_protocol     = prot_reg;
    assign out_ssl          = ssl_reg;
    assign out_port_number  = port_reg;
    assign out_host_start   = hstart_reg;
    assign out_host_length  = hlen_reg;
    assign out_path_present = ppres_reg;
    assign out_path_start   = pstart_reg;

endmodule

`default_nettype wire

// ===== src/url_scheme_host_port_parser_unit.sv =====
`default_nettype none
// Channel   Handshake             Payload
// s_        s_valid / s_ready     s_ch: one URL byte, zero ends the URL
// m_        m_valid / m_ready     status, protocol, ssl, port, host and path offsets
// cfg_      cfg_valid / cfg_ready cfg_index, cfg_data: register write
//
// One byte is taken per cycle while s_ready is high; the scanner updates its state
// and the parallel scheme match vector in that cycle. A terminating byte queues a
// summary in a two-entry queue; the finisher turns it into a registered result.
// s_ready drops only while the queue is full, i.e. when m_ready has been low
// long enough for two finished URLs to back up behind the output register.
// Reset (aresetn low, synchronous) clears the scanner, queue, config and m_valid.

module url_scheme_host_port_parser_unit #(
    parameter int MAX_URL_BYTES  = 1024,
    parameter int SCHEME_ENTRIES = 22
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [4:0]       m_protocol,
    output logic             m_ssl,
    output logic [15:0]      m_port_number,
    output logic [9:0]       m_host_start,
    output logic [9:0]       m_host_length,
    output logic             m_path_present,
    output logic [9:0]       m_path_start,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import url_shp_pkg::*;

    localparam int PW = $clog2(MAX_URL_BYTES);
    localparam int NE = (SCHEME_ENTRIES < TABLE_SIZE) ? SCHEME_ENTRIES : TABLE_SIZE;
    localparam int REC_W = $bits(url_fix_t) + 3 * PW;

    logic             push, full, q_valid, pop;
    logic [REC_W-1:0] push_data, q_data;

    url_shp_front #(
        .PW(PW), .NE(NE), .MAX_BYTES(MAX_URL_BYTES), .REC_W(REC_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ch(s_ch), .in_ready(s_ready),
        .rec_push(push), .rec_data(push_data), .rec_full(full)
    );

    url_shp_fifo #(.WIDTH(REC_W)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(push), .wr_data(push_data), .full(full),
        .rd_valid(q_valid), .rd_en(pop), .rd_data(q_data)
    );

    url_shp_back #(.PW(PW), .NE(NE), .REC_W(REC_W)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cfg_ready(cfg_ready),
        .rec_valid(q_valid), .rec_data(q_data), .rec_pop(pop),
        .out_valid(m_valid), .out_ready(m_ready),
        .out_status(m_status), .out_protocol(m_protocol), .out_ssl(m_ssl),
        .out_port_number(m_port_number), .out_host_start(m_host_start),
        .out_host_length(m_host_length), .out_path_present(m_path_present),
        .out_path_start(m_path_start)
    );

endmodule

`default_nettype wire
